// ===== rtl/flick_gesture_recognizer_assert.svh =====
// assertion macros for the flick gesture recognizer
`ifndef FLICK_GESTURE_RECOGNIZER_ASSERT_SVH
`define FLICK_GESTURE_RECOGNIZER_ASSERT_SVH

`ifndef SYNTHESIS

// consequent must hold in the same cycle as the antecedent
`define FGR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fgr assertion failed: same-cycle implication");

// consequent must hold in the cycle after the antecedent
`define FGR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fgr assertion failed: next-cycle implication");

`else

`define FGR_ASSERT_IMP(lbl, clk, rst, ante, cons)

`define FGR_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/fgr_pkg.sv =====
package fgr_pkg;

   localparam int COORD_BITS = 12;
   localparam int TIME_BITS  = 32;

   localparam int KIND_BITS    = 2;
   localparam int VERDICT_BITS = 3;
   localparam int DIR_BITS     = 3;
   localparam int TIMEOUT_BITS = 16;
   localparam int THRESH_BITS  = 12;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // event kinds
   localparam logic [KIND_BITS-1:0] KIND_PRESS   = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_MOVE    = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_RELEASE = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_UNGRAB  = 2'd3;

   // verdicts
   localparam logic [VERDICT_BITS-1:0] V_IGNORE  = 3'd0;
   localparam logic [VERDICT_BITS-1:0] V_MAYBE   = 3'd1;
   localparam logic [VERDICT_BITS-1:0] V_TRIGGER = 3'd2;
   localparam logic [VERDICT_BITS-1:0] V_FINISH  = 3'd3;
   localparam logic [VERDICT_BITS-1:0] V_CANCEL  = 3'd4;

   // directions
   localparam logic [DIR_BITS-1:0] DIR_NONE  = 3'd0;
   localparam logic [DIR_BITS-1:0] DIR_LEFT  = 3'd1;
   localparam logic [DIR_BITS-1:0] DIR_RIGHT = 3'd2;
   localparam logic [DIR_BITS-1:0] DIR_UP    = 3'd3;
   localparam logic [DIR_BITS-1:0] DIR_DOWN  = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIMEOUT  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_X  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_Y  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FINISH_X = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FINISH_Y = 3'd4;

   // register reset values
   localparam logic [TIMEOUT_BITS-1:0] RST_TIMEOUT  = 16'd300;
   localparam logic [THRESH_BITS-1:0]  RST_START_X  = 12'd50;
   localparam logic [THRESH_BITS-1:0]  RST_START_Y  = 12'd25;
   localparam logic [THRESH_BITS-1:0]  RST_FINISH_X = 12'd300;
   localparam logic [THRESH_BITS-1:0]  RST_FINISH_Y = 12'd200;

   typedef struct packed {
      logic [TIMEOUT_BITS-1:0] timeout_ms;
      logic [THRESH_BITS-1:0]  start_thresh_x;
      logic [THRESH_BITS-1:0]  start_thresh_y;
      logic [THRESH_BITS-1:0]  finish_thresh_x;
      logic [THRESH_BITS-1:0]  finish_thresh_y;
   } cfg_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]  kind;
      logic [COORD_BITS-1:0] pos_x;
      logic [COORD_BITS-1:0] pos_y;
      logic [TIME_BITS-1:0]  stamp_ms;
   } evt_type;

   typedef struct packed {
      logic [VERDICT_BITS-1:0] verdict;
      logic [DIR_BITS-1:0]     flick_dir;
      logic [COORD_BITS-1:0]   flick_dist;
   } res_type;

   typedef struct packed {
      logic tracking;
      logic started;
   } stat_type;

endpackage

// ===== rtl/fgr_csr.sv =====
module fgr_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [fgr_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [fgr_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output fgr_pkg::cfg_type                     cfg
);
   import fgr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_TIMEOUT:  cfg_in.timeout_ms      = csr_wdata[TIMEOUT_BITS-1:0];
            CSR_START_X:  cfg_in.start_thresh_x  = csr_wdata[THRESH_BITS-1:0];
            CSR_START_Y:  cfg_in.start_thresh_y  = csr_wdata[THRESH_BITS-1:0];
            CSR_FINISH_X: cfg_in.finish_thresh_x = csr_wdata[THRESH_BITS-1:0];
            CSR_FINISH_Y: cfg_in.finish_thresh_y = csr_wdata[THRESH_BITS-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ms      <= RST_TIMEOUT;
         cfg_ff.start_thresh_x  <= RST_START_X;
         cfg_ff.start_thresh_y  <= RST_START_Y;
         cfg_ff.finish_thresh_x <= RST_FINISH_X;
         cfg_ff.finish_thresh_y <= RST_FINISH_Y;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/fgr_core.sv =====
module fgr_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               evt_fire,
   input  fgr_pkg::evt_type   evt,
   input  fgr_pkg::cfg_type   cfg,
   output fgr_pkg::res_type   res,
   output fgr_pkg::stat_type  stat
);
   import fgr_pkg::*;

   localparam int ACC_BITS = COORD_BITS + 3;

   function automatic logic thresh_passed(
      input logic [DIR_BITS-1:0]    dir,
      input logic [COORD_BITS-1:0]  span,
      input logic [THRESH_BITS-1:0] tx,
      input logic [THRESH_BITS-1:0] ty
   );
      logic hit;
      if (dir == DIR_NONE) begin
         hit = 1'b0;
      end else if (dir == DIR_LEFT || dir == DIR_RIGHT) begin
         hit = (ACC_BITS'(span) >= ACC_BITS'(tx));
      end else begin
         hit = (ACC_BITS'(span) >= ACC_BITS'(ty));
      end
      return hit;
   endfunction

   // gesture state
   logic                    tracking_ff, tracking_in;
   logic                    started_ff, started_in;
   logic [COORD_BITS-1:0]   origin_x_ff, origin_x_in;
   logic [COORD_BITS-1:0]   origin_y_ff, origin_y_in;
   logic [TIME_BITS-1:0]    origin_time_ff, origin_time_in;
   logic [DIR_BITS-1:0]     cur_dir_ff, cur_dir_in;
   logic [COORD_BITS-1:0]   cur_dist_ff, cur_dist_in;
   logic                    zigzag_ff, zigzag_in;
   logic                    accident_ff, accident_in;

   // measurement
   logic [COORD_BITS-1:0]   abs_x, abs_y;
   logic [DIR_BITS-1:0]     meas_dir;
   logic [COORD_BITS-1:0]   meas_dist;
   logic [COORD_BITS-1:0]   moved;
   logic [ACC_BITS-1:0]     moved_x5, dist_x4;
   logic                    zig_new, acc_new;
   logic                    fin_pass, start_pass;
   logic [TIME_BITS-1:0]    elapsed;
   logic                    timed_out;
   logic [VERDICT_BITS-1:0] verdict;

   always_comb begin
      abs_x = (evt.pos_x >= origin_x_ff) ? evt.pos_x - origin_x_ff : origin_x_ff - evt.pos_x;
      abs_y = (evt.pos_y >= origin_y_ff) ? evt.pos_y - origin_y_ff : origin_y_ff - evt.pos_y;

      // an axis tie keeps the previous direction and distance
      meas_dir  = cur_dir_ff;
      meas_dist = cur_dist_ff;
      if (abs_x > abs_y) begin
         meas_dir  = (evt.pos_x > origin_x_ff) ? DIR_RIGHT : DIR_LEFT;
         meas_dist = abs_x;
      end else if (abs_x < abs_y) begin
         meas_dir  = (evt.pos_y > origin_y_ff) ? DIR_DOWN : DIR_UP;
         meas_dist = abs_y;
      end

      zig_new = zigzag_ff
             || (cur_dir_ff != DIR_NONE && cur_dir_ff != meas_dir)
             || (meas_dist < cur_dist_ff);

      fin_pass   = thresh_passed(meas_dir, meas_dist, cfg.finish_thresh_x,
                                 cfg.finish_thresh_y);
      start_pass = thresh_passed(meas_dir, meas_dist, cfg.start_thresh_x,
                                 cfg.start_thresh_y);

      // moved > floor(4*dist/5) is the same test as 5*moved > 4*dist
      moved    = (meas_dist >= cur_dist_ff) ? meas_dist - cur_dist_ff
                                            : cur_dist_ff - meas_dist;
      moved_x5 = (ACC_BITS'(moved) << 2) + ACC_BITS'(moved);
      dist_x4  = ACC_BITS'(meas_dist) << 2;
      acc_new  = accident_ff;
      if (!accident_ff && fin_pass) begin
         acc_new = (moved_x5 > dist_x4);
      end

      elapsed   = evt.stamp_ms - origin_time_ff;
      timed_out = (elapsed >= TIME_BITS'(cfg.timeout_ms));

      verdict = V_IGNORE;
      if (!started_ff) begin
         if (timed_out || zig_new) begin
            verdict = V_CANCEL;
         end else if (start_pass || fin_pass) begin
            verdict = V_TRIGGER;
         end
      end else begin
         if (timed_out || zig_new || acc_new) begin
            verdict = V_CANCEL;
         end else if (fin_pass) begin
            verdict = V_FINISH;
         end
      end
      if (evt.kind == KIND_RELEASE && verdict != V_FINISH) begin
         verdict = V_CANCEL;
      end
   end

   always_comb begin
      tracking_in    = tracking_ff;
      started_in     = started_ff;
      origin_x_in    = origin_x_ff;
      origin_y_in    = origin_y_ff;
      origin_time_in = origin_time_ff;
      cur_dir_in     = cur_dir_ff;
      cur_dist_in    = cur_dist_ff;
      zigzag_in      = zigzag_ff;
      accident_in    = accident_ff;
      res.verdict    = V_IGNORE;
      res.flick_dir  = DIR_NONE;
      res.flick_dist = '0;

      if (evt.kind == KIND_PRESS) begin
         origin_x_in    = evt.pos_x;
         origin_y_in    = evt.pos_y;
         origin_time_in = evt.stamp_ms;
         cur_dir_in     = DIR_NONE;
         cur_dist_in    = '0;
         zigzag_in      = 1'b0;
         accident_in    = 1'b0;
         started_in     = 1'b0;
         tracking_in    = 1'b1;
         res.verdict    = V_MAYBE;
      end else if (tracking_ff) begin
         if (evt.kind == KIND_UNGRAB) begin
            res.verdict    = V_CANCEL;
            res.flick_dir  = cur_dir_ff;
            res.flick_dist = cur_dist_ff;
            tracking_in    = 1'b0;
            started_in     = 1'b0;
         end else begin
            cur_dir_in     = meas_dir;
            cur_dist_in    = meas_dist;
            zigzag_in      = zig_new;
            accident_in    = acc_new;
            res.verdict    = verdict;
            res.flick_dir  = meas_dir;
            res.flick_dist = meas_dist;
            if (verdict == V_TRIGGER) begin
               started_in = 1'b1;
            end
            if (verdict == V_FINISH || verdict == V_CANCEL) begin
               tracking_in = 1'b0;
               started_in  = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tracking_ff <= 1'b0;
         started_ff  <= 1'b0;
      end else if (evt_fire) begin
         tracking_ff <= tracking_in;
         started_ff  <= started_in;
      end
   end

   // only read while tracking, so no reset needed
   always_ff @(posedge clock) begin
      if (evt_fire) begin
         origin_x_ff    <= origin_x_in;
         origin_y_ff    <= origin_y_in;
         origin_time_ff <= origin_time_in;
         cur_dir_ff     <= cur_dir_in;
         cur_dist_ff    <= cur_dist_in;
         zigzag_ff      <= zigzag_in;
         accident_ff    <= accident_in;
      end
   end

   assign stat.tracking = tracking_ff;
   assign stat.started  = started_ff;

endmodule

// ===== rtl/flick_gesture_recognizer.sv =====
// Flick gesture recognizer: follows one touch from press to release and answers each
// event (press, move, release, ungrab) with one verdict, a major direction and a distance
// from the press point. Events are taken at one per clock, sustained, while the output
// does not stall; an event is held in the input register and its result then in the
// result register, where it stays until taken. The gesture state is updated as the
// event moves into the result register, which is what sets the one-event-per-clock rate.
// An event may be accepted while a result is held stalled on the output; a second one
// waits until that result is taken. Thresholds and timeout are written through the csr_
// port; writing only while no event is in flight is the user's duty, as the block lacks a check.
`include "flick_gesture_recognizer_assert.svh"

module flick_gesture_recognizer (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fgr_pkg::KIND_BITS-1:0]       req_type,
   input  logic [fgr_pkg::COORD_BITS-1:0]      req_pos_x,
   input  logic [fgr_pkg::COORD_BITS-1:0]      req_pos_y,
   input  logic [fgr_pkg::TIME_BITS-1:0]       req_stamp_ms,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [fgr_pkg::VERDICT_BITS-1:0]    rsp_verdict,
   output logic [fgr_pkg::DIR_BITS-1:0]        rsp_flick_dir,
   output logic [fgr_pkg::COORD_BITS-1:0]      rsp_flick_dist,

   input  logic                                csr_write,
   input  logic [fgr_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [fgr_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import fgr_pkg::*;

   cfg_type  cfg;
   stat_type stat;
   res_type  core_res;

   logic     in_v_ff, in_v_in;
   evt_type  in_word_ff;
   logic     rsp_v_ff, rsp_v_in;
   res_type  rsp_word_ff;

   logic     req_take;
   logic     advance;

   // the input word moves on whenever the result register is free or draining
   assign advance   = in_v_ff && (!rsp_v_ff || !rsp_stall);
   assign req_stall = in_v_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_v_in  = req_take || (in_v_ff && !advance);
   assign rsp_v_in = advance || (rsp_v_ff && rsp_stall);

   fgr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fgr_core u_core (
      .clock    (clock),
      .reset    (reset),
      .evt_fire (advance),
      .evt      (in_word_ff),
      .cfg      (cfg),
      .res      (core_res),
      .stat     (stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         in_v_ff  <= in_v_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff.kind     <= req_type;
         in_word_ff.pos_x    <= req_pos_x;
         in_word_ff.pos_y    <= req_pos_y;
         in_word_ff.stamp_ms <= req_stamp_ms;
      end
      if (advance) begin
         rsp_word_ff <= core_res;
      end
   end

   assign rsp_valid      = rsp_v_ff;
   assign rsp_verdict    = rsp_word_ff.verdict;
   assign rsp_flick_dir  = rsp_word_ff.flick_dir;
   assign rsp_flick_dist = rsp_word_ff.flick_dist;

   `FGR_ASSERT_IMP(a_started_needs_tracking, clock, reset, stat.started, stat.tracking)
   `FGR_ASSERT_IMP(a_finish_only_started, clock, reset, advance && core_res.verdict == V_FINISH, stat.started)
   `FGR_ASSERT_NXT(a_advance_fills_result, clock, reset, advance, rsp_v_ff)
   `FGR_ASSERT_IMP(a_maybe_is_blank, clock, reset, rsp_v_ff && rsp_word_ff.verdict == V_MAYBE, rsp_word_ff.flick_dir == DIR_NONE && rsp_word_ff.flick_dist == '0)

endmodule
